[hw/rtl/dsl_byte_tokenizer_assert.svh]
// Assertion macros for the byte tokenizer
`ifndef DSL_BYTE_TOKENIZER_ASSERT_SVH
`define DSL_BYTE_TOKENIZER_ASSERT_SVH
// implication checked on every edge out of reset
`define DBT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define DBT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[hw/rtl/dbt_pkg.sv]
package dbt_pkg;

  localparam int LINE_BITS_DEF   = 16;
  localparam int COLUMN_BITS_DEF = 16;
  localparam int POS_W           = 16;
  localparam int INT_W           = 63;
  localparam int MAX_RES         = 4;
  localparam int QDEPTH          = 4;

  typedef enum logic [3:0] {
    M_IDLE, M_SLASH, M_IDENT, M_INT, M_STR, M_ESC, M_COMMENT,
    M_BANG, M_EQ, M_LT, M_GT, M_AMP, M_BAR, M_HALT
  } mode_t;

  typedef enum logic [2:0] {
    ERR_NONE, ERR_UNEXP, ERR_OVFL, ERR_UNTERM, ERR_ESC
  } err_t;

  localparam logic [4:0] K_END = 5'd0, K_IDENT = 5'd1, K_INT = 5'd2, K_STR = 5'd3,
    K_LBRACE = 5'd4, K_RBRACE = 5'd5, K_LBRACK = 5'd6, K_RBRACK = 5'd7,
    K_LPAREN = 5'd8, K_RPAREN = 5'd9, K_COLON = 5'd10, K_COMMA = 5'd11,
    K_DOT = 5'd12, K_PLUS = 5'd13, K_STAR = 5'd14, K_SLASH = 5'd15,
    K_BANG = 5'd16, K_NE = 5'd17, K_ASSIGN = 5'd18, K_EQEQ = 5'd19,
    K_ARROW = 5'd20, K_LT = 5'd21, K_LE = 5'd22, K_GT = 5'd23, K_GE = 5'd24,
    K_ANDAND = 5'd25, K_OROR = 5'd26, K_MINUS = 5'd27;

  // one result record
  typedef struct packed {
    logic [4:0]       kind;
    logic [POS_W-1:0] line;
    logic [POS_W-1:0] col;
    logic             has_byte;
    logic [7:0]       text;
    logic             done;
    logic [INT_W-1:0] ival;
    err_t             err;
    logic             last;
  } rec_t;

  // a group of up to four records caused by one byte
  typedef struct packed {
    logic [2:0]             cnt;
    rec_t [MAX_RES-1:0]     recs;
  } grp_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c == 8'h5F;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // single-byte punctuation kind, K_END when none
  function automatic logic [4:0] punct_kind(input logic [7:0] c);
    case (c)
      8'h7B: return K_LBRACE;
      8'h7D: return K_RBRACE;
      8'h5B: return K_LBRACK;
      8'h5D: return K_RBRACK;
      8'h28: return K_LPAREN;
      8'h29: return K_RPAREN;
      8'h3A: return K_COLON;
      8'h2C: return K_COMMA;
      8'h2E: return K_DOT;
      8'h2B: return K_PLUS;
      8'h2A: return K_STAR;
      8'h2D: return K_MINUS;
      default: return K_END;
    endcase
  endfunction

endpackage

[hw/rtl/dbt_if.sv]
interface dbt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_of_source;
  modport source (output valid, source_byte, end_of_source, input ready);
  modport sink (input valid, source_byte, end_of_source, output ready);
endinterface

interface dbt_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic        has_byte;
  logic [7:0]  text_byte;
  logic        token_done;
  logic [62:0] int_value;
  logic [2:0]  error_code;
  logic        last_of_run;
  modport source (output valid, token_kind, start_line, start_column, has_byte,
                  text_byte, token_done, int_value, error_code, last_of_run,
                  input ready);
  modport sink (input valid, token_kind, start_line, start_column, has_byte,
                text_byte, token_done, int_value, error_code, last_of_run,
                output ready);
endinterface

[hw/rtl/dsl_byte_tokenizer.sv]
// Channel | Dir | Payload
// in_*    | in  | source_byte, end_of_source
// out_*   | out | one token record per transfer
// Takes one byte per cycle; each byte yields up to four records, sent one per cycle.
// The front lexer is combinational over its registered state; the back serializer drains a four-group queue.
// Input stalls only when that queue is full; output stalls hold the head record.
// Synchronous active-low reset returns to line 1, column 1, idle mode.
`include "dsl_byte_tokenizer_assert.svh"
module dsl_byte_tokenizer #(
  parameter int LINE_BITS   = dbt_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = dbt_pkg::COLUMN_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  dbt_in_if.sink    in_ch,
  dbt_out_if.source out_ch
);
  dbt_pkg::grp_t grp;
  dbt_pkg::rec_t rec;
  logic          full, acc;

  assign in_ch.ready = !full;
  assign acc = in_ch.valid && !full;

  dbt_front #(.LINE_BITS(LINE_BITS), .COLUMN_BITS(COLUMN_BITS)) u_front (
    .clk, .rst_n, .acc, .b(in_ch.source_byte), .eos(in_ch.end_of_source), .grp
  );

  dbt_back u_back (
    .clk, .rst_n, .push(acc), .grp, .full,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .rec
  );

  assign out_ch.token_kind   = rec.kind;
  assign out_ch.start_line   = rec.line;
  assign out_ch.start_column = rec.col;
  assign out_ch.has_byte     = rec.has_byte;
  assign out_ch.text_byte    = rec.text;
  assign out_ch.token_done   = rec.done;
  assign out_ch.int_value    = rec.ival;
  assign out_ch.error_code   = rec.err;
  assign out_ch.last_of_run  = rec.last;

  `DBT_ASSERT_IMP(a_full_no_acc, full, !acc)
  `DBT_ASSERT_IMP(a_eos_group, acc && in_ch.end_of_source, grp.cnt != 3'd0)
  `DBT_ASSERT_NXT(a_reset_empty, !rst_n, !out_ch.valid)
endmodule

[hw/rtl/dbt_front.sv]
// Lexer front: one byte per cycle while acc is high, produces a record group per byte
module dbt_front #(
  parameter int LINE_BITS   = dbt_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = dbt_pkg::COLUMN_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  logic [7:0]    b,
  input  logic          eos,
  output dbt_pkg::grp_t grp
);
  localparam logic [LINE_BITS-1:0]   LMAX = {LINE_BITS{1'b1}};
  localparam logic [COLUMN_BITS-1:0] CMAX = {COLUMN_BITS{1'b1}};
  localparam logic [62:0] MAX63 = {63{1'b1}};
  // largest value that still takes a digit; at exactly THR only digits up to '7' fit
  localparam logic [62:0] THR = MAX63 / 63'd10;

  dbt_pkg::mode_t         mode_r, mode_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt, tline_r, tline_nxt;
  logic [COLUMN_BITS-1:0] col_r, col_nxt, tcol_r, tcol_nxt;
  logic [62:0]            acc_r, acc_nxt;
  logic                   ovf_r, ovf_nxt;

  logic [dbt_pkg::POS_W-1:0] cl, cc, tl, tc;
  logic [62:0] d63;
  logic [66:0] prod;

  assign cl = dbt_pkg::POS_W'(line_r);
  assign cc = dbt_pkg::POS_W'(col_r);
  assign d63 = 63'(b - 8'h30);
  assign prod = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {4'b0000, d63};

  always_comb begin
    dbt_pkg::rec_t r;
    logic          ws, reproc, halt;
    logic [4:0]    pk;
    r = '0;
    grp = '0;
    mode_nxt = mode_r; line_nxt = line_r; col_nxt = col_r;
    tline_nxt = tline_r; tcol_nxt = tcol_r; acc_nxt = acc_r; ovf_nxt = ovf_r;
    tl = dbt_pkg::POS_W'(tline_r);
    tc = dbt_pkg::POS_W'(tcol_r);
    ws = b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0A;
    reproc = 1'b0;
    halt = 1'b0;
    pk = dbt_pkg::punct_kind(b);
    if (acc) begin
      if (eos) begin
        // flush then End
        case (mode_r)
          dbt_pkg::M_IDENT: begin
            r = '0; r.kind = dbt_pkg::K_IDENT; r.line = tl; r.col = tc; r.done = 1'b1;
            grp.recs[grp.cnt[1:0]] = r; grp.cnt = grp.cnt + 3'd1;
          end
          dbt_pkg::M_INT: begin
            r = '0; r.line = tl; r.col = tc;
            if (ovf_r) r.err = dbt_pkg::ERR_OVFL;
            else begin r.kind = dbt_pkg::K_INT; r.done = 1'b1; r.ival = acc_r; end
            grp.recs[grp.cnt[1:0]] = r; grp.cnt = grp.cnt + 3'd1;
          end
          dbt_pkg::M_STR, dbt_pkg::M_AMP, dbt_pkg::M_BAR: begin
            r = '0; r.line = tl; r.col = tc;
            r.err = (mode_r == dbt_pkg::M_STR) ? dbt_pkg::ERR_UNTERM : dbt_pkg::ERR_UNEXP;
            grp.recs[grp.cnt[1:0]] = r; grp.cnt = grp.cnt + 3'd1;
          end
          dbt_pkg::M_ESC: begin
            r = '0; r.line = cl;
            r.col = (col_r > COLUMN_BITS'(1)) ? dbt_pkg::POS_W'(col_r - COLUMN_BITS'(1)) : cc;
            r.err = dbt_pkg::ERR_ESC;
            grp.recs[grp.cnt[1:0]] = r; grp.cnt = grp.cnt + 3'd1;
          end
          dbt_pkg::M_SLASH, dbt_pkg::M_BANG, dbt_pkg::M_EQ, dbt_pkg::M_LT,
          dbt_pkg::M_GT: begin
            r = '0; r.line = tl; r.col = tc; r.has_byte = 1'b1;
            case (mode_r)
              dbt_pkg::M_SLASH: begin r.kind = dbt_pkg::K_SLASH; r.text = 8'h2F; end
              dbt_pkg::M_BANG: begin r.kind = dbt_pkg::K_BANG; r.text = 8'h21; end
              dbt_pkg::M_EQ: begin r.kind = dbt_pkg::K_ASSIGN; r.text = 8'h3D; end
              dbt_pkg::M_LT: begin r.kind = dbt_pkg::K_LT; r.text = 8'h3C; end
              default: begin r.kind = dbt_pkg::K_GT; r.text = 8'h3E; end
            endcase
            grp.recs[0] = r;
            r.has_byte = 1'b0; r.text = '0; r.done = 1'b1;
            grp.recs[1] = r; grp.cnt = 3'd2;
          end
          default: ;
        endcase
        r = '0; r.line = cl; r.col = cc; r.done = 1'b1;
        grp.recs[grp.cnt[1:0]] = r; grp.cnt = grp.cnt + 3'd1;
        mode_nxt = dbt_pkg::M_IDLE;
        line_nxt = LINE_BITS'(1); col_nxt = COLUMN_BITS'(1);
        tline_nxt = LINE_BITS'(1); tcol_nxt = COLUMN_BITS'(1);
        acc_nxt = '0; ovf_nxt = 1'b0;
      end else if (mode_r != dbt_pkg::M_HALT) begin
        // pass one: the pending-state part
        case (mode_r)
          dbt_pkg::M_IDLE: reproc = 1'b1;
          dbt_pkg::M_IDENT: begin
            r = '0; r.kind = dbt_pkg::K_IDENT; r.line = tl; r.col = tc;
            if (dbt_pkg::is_alpha(b) || dbt_pkg::is_digit(b)) begin
              r.has_byte = 1'b1; r.text = b;
            end else begin
              r.done = 1'b1; reproc = 1'b1;
            end
            grp.recs[0] = r; grp.cnt = 3'd1;
          end
          dbt_pkg::M_INT: begin
            r = '0; r.line = tl; r.col = tc;
            if (dbt_pkg::is_digit(b)) begin
              if (!ovf_r) begin
                if (acc_r > THR || (acc_r == THR && b > 8'h37)) ovf_nxt = 1'b1;
                else acc_nxt = prod[62:0];
              end
              r.kind = dbt_pkg::K_INT; r.has_byte = 1'b1; r.text = b;
            end else if (ovf_r) begin
              r.err = dbt_pkg::ERR_OVFL; halt = 1'b1;
            end else begin
              r.kind = dbt_pkg::K_INT; r.done = 1'b1; r.ival = acc_r;
              reproc = 1'b1;
            end
            grp.recs[0] = r; grp.cnt = 3'd1;
          end
          dbt_pkg::M_STR: begin
            r = '0; r.kind = dbt_pkg::K_STR; r.line = tl; r.col = tc;
            if (b == 8'h22) begin
              r.done = 1'b1; mode_nxt = dbt_pkg::M_IDLE;
              grp.recs[0] = r; grp.cnt = 3'd1;
            end else if (b == 8'h0A || b == 8'h0D) begin
              r.kind = dbt_pkg::K_END; r.err = dbt_pkg::ERR_UNTERM; halt = 1'b1;
              grp.recs[0] = r; grp.cnt = 3'd1;
            end else if (b == 8'h5C) mode_nxt = dbt_pkg::M_ESC;
            else begin
              r.has_byte = 1'b1; r.text = b;
              grp.recs[0] = r; grp.cnt = 3'd1;
            end
          end
          dbt_pkg::M_ESC: begin
            r = '0; r.kind = dbt_pkg::K_STR; r.line = tl; r.col = tc; r.has_byte = 1'b1;
            mode_nxt = dbt_pkg::M_STR;
            case (b)
              8'h22: r.text = 8'h22;
              8'h5C: r.text = 8'h5C;
              8'h6E: r.text = 8'h0A;
              8'h74: r.text = 8'h09;
              default: begin
                r = '0; r.line = cl; r.col = cc; r.err = dbt_pkg::ERR_ESC; halt = 1'b1;
              end
            endcase
            grp.recs[0] = r; grp.cnt = 3'd1;
          end
          dbt_pkg::M_COMMENT: if (b == 8'h0A) mode_nxt = dbt_pkg::M_IDLE;
          dbt_pkg::M_AMP, dbt_pkg::M_BAR: begin
            r = '0; r.line = tl; r.col = tc;
            if ((mode_r == dbt_pkg::M_AMP && b == 8'h26) ||
                (mode_r == dbt_pkg::M_BAR && b == 8'h7C)) begin
              r.kind = (mode_r == dbt_pkg::M_AMP) ? dbt_pkg::K_ANDAND : dbt_pkg::K_OROR;
              r.has_byte = 1'b1; r.text = b;
              grp.recs[0] = r; grp.recs[1] = r;
              r.has_byte = 1'b0; r.text = '0; r.done = 1'b1;
              grp.recs[2] = r; grp.cnt = 3'd3; mode_nxt = dbt_pkg::M_IDLE;
            end else begin
              r.err = dbt_pkg::ERR_UNEXP; halt = 1'b1;
              grp.recs[0] = r; grp.cnt = 3'd1;
            end
          end
          dbt_pkg::M_SLASH: begin
            if (b == 8'h2F) mode_nxt = dbt_pkg::M_COMMENT;
            else begin
              r = '0; r.kind = dbt_pkg::K_SLASH; r.line = tl; r.col = tc;
              r.has_byte = 1'b1; r.text = 8'h2F; grp.recs[0] = r;
              r.has_byte = 1'b0; r.text = '0; r.done = 1'b1; grp.recs[1] = r;
              grp.cnt = 3'd2; reproc = 1'b1;
            end
          end
          default: begin
            // '!', '=', '<', '>' lookahead
            logic [7:0] c0;
            logic [4:0] k1, k2;
            logic       two;
            r = '0; r.line = tl; r.col = tc;
            two = 1'b0; k2 = dbt_pkg::K_END;
            case (mode_r)
              dbt_pkg::M_BANG: begin c0 = 8'h21; k1 = dbt_pkg::K_BANG;
                two = b == 8'h3D; k2 = dbt_pkg::K_NE; end
              dbt_pkg::M_EQ: begin c0 = 8'h3D; k1 = dbt_pkg::K_ASSIGN;
                two = b == 8'h3D || b == 8'h3E;
                k2 = (b == 8'h3D) ? dbt_pkg::K_EQEQ : dbt_pkg::K_ARROW; end
              dbt_pkg::M_LT: begin c0 = 8'h3C; k1 = dbt_pkg::K_LT;
                two = b == 8'h3D; k2 = dbt_pkg::K_LE; end
              default: begin c0 = 8'h3E; k1 = dbt_pkg::K_GT;
                two = b == 8'h3D; k2 = dbt_pkg::K_GE; end
            endcase
            r.has_byte = 1'b1; r.text = c0;
            if (two) begin
              r.kind = k2; grp.recs[0] = r;
              r.text = b; grp.recs[1] = r;
              r.has_byte = 1'b0; r.text = '0; r.done = 1'b1; grp.recs[2] = r;
              grp.cnt = 3'd3; mode_nxt = dbt_pkg::M_IDLE;
            end else begin
              r.kind = k1; grp.recs[0] = r;
              r.has_byte = 1'b0; r.text = '0; r.done = 1'b1; grp.recs[1] = r;
              grp.cnt = 3'd2; reproc = 1'b1;
            end
          end
        endcase
        // pass two: the byte as the start of a token
        if (reproc) begin
          mode_nxt = dbt_pkg::M_IDLE;
          if (!ws) begin
            tline_nxt = line_r; tcol_nxt = col_r;
            r = '0; r.line = cl; r.col = cc;
            if (dbt_pkg::is_alpha(b)) begin
              mode_nxt = dbt_pkg::M_IDENT;
              r.kind = dbt_pkg::K_IDENT; r.has_byte = 1'b1; r.text = b;
              grp.recs[grp.cnt[1:0]] = r; grp.cnt = grp.cnt + 3'd1;
            end else if (dbt_pkg::is_digit(b)) begin
              mode_nxt = dbt_pkg::M_INT; acc_nxt = d63; ovf_nxt = 1'b0;
              r.kind = dbt_pkg::K_INT; r.has_byte = 1'b1; r.text = b;
              grp.recs[grp.cnt[1:0]] = r; grp.cnt = grp.cnt + 3'd1;
            end else begin
              case (b)
                8'h22: mode_nxt = dbt_pkg::M_STR;
                8'h2F: mode_nxt = dbt_pkg::M_SLASH;
                8'h21: mode_nxt = dbt_pkg::M_BANG;
                8'h3D: mode_nxt = dbt_pkg::M_EQ;
                8'h3C: mode_nxt = dbt_pkg::M_LT;
                8'h3E: mode_nxt = dbt_pkg::M_GT;
                8'h26: mode_nxt = dbt_pkg::M_AMP;
                8'h7C: mode_nxt = dbt_pkg::M_BAR;
                default: begin
                  if (pk != dbt_pkg::K_END) begin
                    r.kind = pk; r.has_byte = 1'b1; r.text = b;
                    grp.recs[grp.cnt[1:0]] = r;
                    r.has_byte = 1'b0; r.text = '0; r.done = 1'b1;
                    grp.recs[grp.cnt[1:0] + 2'd1] = r; grp.cnt = grp.cnt + 3'd2;
                  end else begin
                    r.err = dbt_pkg::ERR_UNEXP; halt = 1'b1;
                    grp.recs[grp.cnt[1:0]] = r; grp.cnt = grp.cnt + 3'd1;
                  end
                end
              endcase
            end
          end
        end
        if (halt) mode_nxt = dbt_pkg::M_HALT;
        else if (b == 8'h0A) begin
          if (line_r != LMAX) line_nxt = line_r + LINE_BITS'(1);
          col_nxt = COLUMN_BITS'(1);
        end else if (col_r != CMAX) col_nxt = col_r + COLUMN_BITS'(1);
      end
      if (grp.cnt != 3'd0) grp.recs[grp.cnt[1:0] - 2'd1].last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= dbt_pkg::M_IDLE;
      line_r <= LINE_BITS'(1); col_r <= COLUMN_BITS'(1);
      tline_r <= LINE_BITS'(1); tcol_r <= COLUMN_BITS'(1);
      acc_r <= '0; ovf_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt; line_r <= line_nxt; col_r <= col_nxt;
      tline_r <= tline_nxt; tcol_r <= tcol_nxt; acc_r <= acc_nxt; ovf_r <= ovf_nxt;
    end
  end
endmodule

[hw/rtl/dbt_back.sv]
// Group queue and record serializer
module dbt_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dbt_pkg::grp_t grp,
  output logic          full,
  output logic          out_valid,
  input  logic          out_ready,
  output dbt_pkg::rec_t rec
);
  localparam int AW = $clog2(dbt_pkg::QDEPTH);

  dbt_pkg::grp_t   mem_r [dbt_pkg::QDEPTH];
  logic [AW-1:0]   wp_r, rp_r;
  logic [AW:0]     cnt_r, cnt_nxt;
  logic [1:0]      idx_r;
  logic            pop_rec, pop_grp, wr;
  dbt_pkg::grp_t   head;

  assign head = mem_r[rp_r];
  assign wr = push && grp.cnt != 3'd0;
  assign full = cnt_r == (AW+1)'(dbt_pkg::QDEPTH);
  assign out_valid = cnt_r != '0;
  assign rec = head.recs[idx_r];
  assign pop_rec = out_valid && out_ready;
  assign pop_grp = pop_rec && rec.last;

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr && !pop_grp) cnt_nxt = cnt_r + (AW+1)'(1);
    else if (!wr && pop_grp) cnt_nxt = cnt_r - (AW+1)'(1);
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= grp;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0; idx_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (wr) wp_r <= wp_r + AW'(1);
      if (pop_grp) begin
        rp_r <= rp_r + AW'(1); idx_r <= '0;
      end else if (pop_rec) idx_r <= idx_r + 2'd1;
    end
  end
endmodule

[dv/dsl_byte_tokenizer_tb.sv]
`timescale 1ns / 100ps
module dsl_byte_tokenizer_tb;

  localparam logic [7:0] CH_TAB = 8'h09, CH_LF = 8'h0A, CH_CR = 8'h0D, CH_NUL = 8'h00;
  localparam logic [63:0] INT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dbt_in_if  in_if();
  dbt_out_if out_if();

  dsl_byte_tokenizer dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // lexer shadow state
  dbt_pkg::mode_t lx_mode;
  logic [15:0]    lx_line, lx_col, tok_line, tok_col;
  logic [62:0]    int_acc;
  logic           int_ovf;
  int             rec_cnt;

  dbt_pkg::rec_t pending_recs[$];
  logic [7:0]    src_bytes[$];
  logic          src_eos[$];
  int            mismatches = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  int            hold_req = 0;

  function automatic logic alpha_c(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
  endfunction

  function automatic logic digit_c(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void lx_reset();
    lx_mode = dbt_pkg::M_IDLE;
    lx_line = 16'd1; lx_col = 16'd1;
    tok_line = 16'd1; tok_col = 16'd1;
    int_acc = '0; int_ovf = 1'b0;
  endfunction

  function automatic void lx_emit(input logic [4:0] k, input logic [15:0] ln,
                                  input logic [15:0] cl, input logic hb,
                                  input logic [7:0] tb, input logic dn,
                                  input logic [62:0] iv, input dbt_pkg::err_t er);
    dbt_pkg::rec_t r;
    if (rec_cnt >= 4) return;
    r.kind = k; r.line = ln; r.col = cl; r.has_byte = hb; r.text = tb;
    r.done = dn; r.ival = iv; r.err = er; r.last = 1'b0;
    pending_recs = {pending_recs, r};
    rec_cnt++;
  endfunction

  function automatic void lx_text(input logic [4:0] k, input logic [7:0] b);
    lx_emit(k, tok_line, tok_col, 1'b1, b, 1'b0, '0, dbt_pkg::ERR_NONE);
  endfunction

  function automatic void lx_done(input logic [4:0] k, input logic [62:0] iv);
    lx_emit(k, tok_line, tok_col, 1'b0, 8'h00, 1'b1, iv, dbt_pkg::ERR_NONE);
  endfunction

  function automatic void lx_fail(input dbt_pkg::err_t e, input logic [15:0] ln,
                                  input logic [15:0] cl);
    lx_emit(dbt_pkg::K_END, ln, cl, 1'b0, 8'h00, 1'b0, '0, e);
    lx_mode = dbt_pkg::M_HALT;
  endfunction

  function automatic void lx_p1(input logic [7:0] c, input logic [4:0] k);
    lx_text(k, c); lx_done(k, '0); lx_mode = dbt_pkg::M_IDLE;
  endfunction

  function automatic void lx_p2(input logic [7:0] c0, input logic [7:0] c1,
                                input logic [4:0] k);
    lx_text(k, c0); lx_text(k, c1); lx_done(k, '0); lx_mode = dbt_pkg::M_IDLE;
  endfunction

  // byte seen between tokens
  function automatic void lx_idle(input logic [7:0] b);
    logic [4:0] k;
    k = dbt_pkg::K_END;
    if (b == " " || b == CH_TAB || b == CH_CR || b == CH_LF) return;
    tok_line = lx_line; tok_col = lx_col;
    if (alpha_c(b)) begin
      lx_mode = dbt_pkg::M_IDENT; lx_text(dbt_pkg::K_IDENT, b); return;
    end
    if (digit_c(b)) begin
      lx_mode = dbt_pkg::M_INT; int_acc = 63'(b - "0"); int_ovf = 1'b0;
      lx_text(dbt_pkg::K_INT, b); return;
    end
    case (b)
      "\"": begin lx_mode = dbt_pkg::M_STR; return; end
      "/": begin lx_mode = dbt_pkg::M_SLASH; return; end
      "!": begin lx_mode = dbt_pkg::M_BANG; return; end
      "=": begin lx_mode = dbt_pkg::M_EQ; return; end
      "<": begin lx_mode = dbt_pkg::M_LT; return; end
      ">": begin lx_mode = dbt_pkg::M_GT; return; end
      "&": begin lx_mode = dbt_pkg::M_AMP; return; end
      "|": begin lx_mode = dbt_pkg::M_BAR; return; end
      "{": k = dbt_pkg::K_LBRACE;
      "}": k = dbt_pkg::K_RBRACE;
      "[": k = dbt_pkg::K_LBRACK;
      "]": k = dbt_pkg::K_RBRACK;
      "(": k = dbt_pkg::K_LPAREN;
      ")": k = dbt_pkg::K_RPAREN;
      ":": k = dbt_pkg::K_COLON;
      ",": k = dbt_pkg::K_COMMA;
      ".": k = dbt_pkg::K_DOT;
      "+": k = dbt_pkg::K_PLUS;
      "*": k = dbt_pkg::K_STAR;
      "-": k = dbt_pkg::K_MINUS;
      default: k = dbt_pkg::K_END;
    endcase
    if (k != dbt_pkg::K_END) lx_p1(b, k);
    else lx_fail(dbt_pkg::ERR_UNEXP, tok_line, tok_col);
  endfunction

  function automatic void lx_byte(input logic [7:0] b);
    logic [63:0] d;
    logic [7:0]  v;
    case (lx_mode)
      dbt_pkg::M_IDLE: lx_idle(b);
      dbt_pkg::M_IDENT: begin
        if (alpha_c(b) || digit_c(b)) lx_text(dbt_pkg::K_IDENT, b);
        else begin
          lx_done(dbt_pkg::K_IDENT, '0); lx_mode = dbt_pkg::M_IDLE; lx_idle(b);
        end
      end
      dbt_pkg::M_INT: begin
        if (digit_c(b)) begin
          d = 64'(b - "0");
          if (!int_ovf) begin
            if ({1'b0, int_acc} > (INT_MAX - d) / 10) int_ovf = 1'b1;
            else int_acc = 63'({1'b0, int_acc} * 10 + d);
          end
          lx_text(dbt_pkg::K_INT, b);
        end else if (int_ovf) begin
          lx_fail(dbt_pkg::ERR_OVFL, tok_line, tok_col);
        end else begin
          lx_done(dbt_pkg::K_INT, int_acc); lx_mode = dbt_pkg::M_IDLE; lx_idle(b);
        end
      end
      dbt_pkg::M_STR: begin
        if (b == "\"") begin
          lx_done(dbt_pkg::K_STR, '0); lx_mode = dbt_pkg::M_IDLE;
        end else if (b == CH_LF || b == CH_CR) begin
          lx_fail(dbt_pkg::ERR_UNTERM, tok_line, tok_col);
        end else if (b == "\\") lx_mode = dbt_pkg::M_ESC;
        else lx_text(dbt_pkg::K_STR, b);
      end
      dbt_pkg::M_ESC: begin
        if (b == "\"" || b == "\\" || b == "n" || b == "t") begin
          v = (b == "n") ? CH_LF : (b == "t") ? CH_TAB : b;
          lx_text(dbt_pkg::K_STR, v); lx_mode = dbt_pkg::M_STR;
        end else lx_fail(dbt_pkg::ERR_ESC, lx_line, lx_col);
      end
      dbt_pkg::M_COMMENT: if (b == CH_LF) lx_mode = dbt_pkg::M_IDLE;
      dbt_pkg::M_SLASH: begin
        if (b == "/") lx_mode = dbt_pkg::M_COMMENT;
        else begin lx_p1("/", dbt_pkg::K_SLASH); lx_idle(b); end
      end
      dbt_pkg::M_BANG: begin
        if (b == "=") lx_p2("!", "=", dbt_pkg::K_NE);
        else begin lx_p1("!", dbt_pkg::K_BANG); lx_idle(b); end
      end
      dbt_pkg::M_EQ: begin
        if (b == "=") lx_p2("=", "=", dbt_pkg::K_EQEQ);
        else if (b == ">") lx_p2("=", ">", dbt_pkg::K_ARROW);
        else begin lx_p1("=", dbt_pkg::K_ASSIGN); lx_idle(b); end
      end
      dbt_pkg::M_LT: begin
        if (b == "=") lx_p2("<", "=", dbt_pkg::K_LE);
        else begin lx_p1("<", dbt_pkg::K_LT); lx_idle(b); end
      end
      dbt_pkg::M_GT: begin
        if (b == "=") lx_p2(">", "=", dbt_pkg::K_GE);
        else begin lx_p1(">", dbt_pkg::K_GT); lx_idle(b); end
      end
      dbt_pkg::M_AMP: begin
        if (b == "&") lx_p2("&", "&", dbt_pkg::K_ANDAND);
        else lx_fail(dbt_pkg::ERR_UNEXP, tok_line, tok_col);
      end
      dbt_pkg::M_BAR: begin
        if (b == "|") lx_p2("|", "|", dbt_pkg::K_OROR);
        else lx_fail(dbt_pkg::ERR_UNEXP, tok_line, tok_col);
      end
      default: ;
    endcase
  endfunction

  // end marker: flush pending token, then End record
  function automatic void lx_end();
    case (lx_mode)
      dbt_pkg::M_IDENT: lx_done(dbt_pkg::K_IDENT, '0);
      dbt_pkg::M_INT: begin
        if (int_ovf) lx_fail(dbt_pkg::ERR_OVFL, tok_line, tok_col);
        else lx_done(dbt_pkg::K_INT, int_acc);
      end
      dbt_pkg::M_STR: lx_fail(dbt_pkg::ERR_UNTERM, tok_line, tok_col);
      dbt_pkg::M_ESC:
        lx_fail(dbt_pkg::ERR_ESC, lx_line, (lx_col > 16'd1) ? lx_col - 16'd1 : lx_col);
      dbt_pkg::M_SLASH: lx_p1("/", dbt_pkg::K_SLASH);
      dbt_pkg::M_BANG: lx_p1("!", dbt_pkg::K_BANG);
      dbt_pkg::M_EQ: lx_p1("=", dbt_pkg::K_ASSIGN);
      dbt_pkg::M_LT: lx_p1("<", dbt_pkg::K_LT);
      dbt_pkg::M_GT: lx_p1(">", dbt_pkg::K_GT);
      dbt_pkg::M_AMP, dbt_pkg::M_BAR: lx_fail(dbt_pkg::ERR_UNEXP, tok_line, tok_col);
      default: ;
    endcase
    lx_emit(dbt_pkg::K_END, lx_line, lx_col, 1'b0, 8'h00, 1'b1, '0, dbt_pkg::ERR_NONE);
  endfunction

  // predict records for one accepted transfer; returns index of first new record
  function automatic int lx_accept(input logic [7:0] b, input logic eos);
    int first;
    first = pending_recs.size();
    rec_cnt = 0;
    if (eos) begin
      lx_end(); lx_reset();
    end else if (lx_mode != dbt_pkg::M_HALT) begin
      lx_byte(b);
      if (lx_mode != dbt_pkg::M_HALT) begin
        if (b == CH_LF) begin
          if (lx_line != 16'hFFFF) lx_line++;
          lx_col = 16'd1;
        end else if (lx_col != 16'hFFFF) lx_col++;
      end
    end
    if (rec_cnt > 0) pending_recs[pending_recs.size() - 1].last = 1'b1;
    return first;
  endfunction

  // directed stimulus: expected kind/error typed only on obvious rows
  typedef struct {
    logic [7:0]    b;
    logic          eos;
    logic          chk;
    logic [4:0]    kind;
    dbt_pkg::err_t err;
  } row_t;

  row_t dir_rows[] = '{
    '{"a", 0, 0, dbt_pkg::K_END, dbt_pkg::ERR_NONE},
    '{"Z", 0, 0, dbt_pkg::K_END, dbt_pkg::ERR_NONE},
    '{"_", 0, 0, dbt_pkg::K_END, dbt_pkg::ERR_NONE},
    '{"9", 0, 0, dbt_pkg::K_END, dbt_pkg::ERR_NONE},
    '{" ", 0, 0, dbt_pkg::K_END, dbt_pkg::ERR_NONE},
    '{"1", 0, 0, dbt_pkg::K_END, dbt_pkg::ERR_NONE},
    '{"2", 0, 0, dbt_pkg::K_END, dbt_pkg::ERR_NONE},
    '{":", 0, 0, dbt_pkg::K_END, dbt_pkg::ERR_NONE},
    '{"\"", 0, 0, dbt_pkg::K_END, dbt_pkg::ERR_NONE},
    '{CH_NUL, 0, 0, dbt_pkg::K_END, dbt_pkg::ERR_NONE},
    '{"\\", 0, 0, dbt_pkg::K_END, dbt_pkg::ERR_NONE},
    '{"n", 0, 0, dbt_pkg::K_END, dbt_pkg::ERR_NONE},
    '{"\"", 0, 1, dbt_pkg::K_STR, dbt_pkg::ERR_NONE},
    '{"=", 0, 0, dbt_pkg::K_END, dbt_pkg::ERR_NONE},
    '{">", 0, 1, dbt_pkg::K_ARROW, dbt_pkg::ERR_NONE},
    '{8'hFF, 0, 1, dbt_pkg::K_END, dbt_pkg::ERR_UNEXP},
    '{"a", 0, 0, dbt_pkg::K_END, dbt_pkg::ERR_NONE},
    '{8'h00, 1, 1, dbt_pkg::K_END, dbt_pkg::ERR_NONE},
    '{"&", 0, 0, dbt_pkg::K_END, dbt_pkg::ERR_NONE},
    '{"x", 0, 1, dbt_pkg::K_END, dbt_pkg::ERR_UNEXP},
    '{8'hFF, 1, 1, dbt_pkg::K_END, dbt_pkg::ERR_NONE},
    '{"/", 0, 0, dbt_pkg::K_END, dbt_pkg::ERR_NONE},
    '{"/", 0, 0, dbt_pkg::K_END, dbt_pkg::ERR_NONE},
    '{CH_NUL, 0, 0, dbt_pkg::K_END, dbt_pkg::ERR_NONE},
    '{CH_LF, 0, 0, dbt_pkg::K_END, dbt_pkg::ERR_NONE},
    '{CH_NUL, 0, 1, dbt_pkg::K_END, dbt_pkg::ERR_UNEXP},
    '{"a", 1, 1, dbt_pkg::K_END, dbt_pkg::ERR_NONE},
    '{"\"", 0, 0, dbt_pkg::K_END, dbt_pkg::ERR_NONE},
    '{"\\", 0, 0, dbt_pkg::K_END, dbt_pkg::ERR_NONE},
    '{"q", 0, 1, dbt_pkg::K_END, dbt_pkg::ERR_ESC},
    '{"x", 1, 1, dbt_pkg::K_END, dbt_pkg::ERR_NONE},
    '{"\"", 0, 0, dbt_pkg::K_END, dbt_pkg::ERR_NONE},
    '{CH_LF, 0, 1, dbt_pkg::K_END, dbt_pkg::ERR_UNTERM},
    '{"a", 1, 1, dbt_pkg::K_END, dbt_pkg::ERR_NONE},
    '{"<", 0, 0, dbt_pkg::K_END, dbt_pkg::ERR_NONE},
    '{"a", 1, 1, dbt_pkg::K_LT, dbt_pkg::ERR_NONE}
  };

  function automatic void put_item(input logic [7:0] b, input logic eos);
    src_bytes = {src_bytes, b};
    src_eos = {src_eos, eos};
  endfunction

  function automatic void put(input logic [7:0] b);
    put_item(b, 1'b0);
  endfunction

  // random well-formed fragments mixed with noise
  function automatic void gen_fragment();
    string p2[] = '{"!=", "==", "=>", "<=", ">=", "&&", "||", "= ", "< ", "> ", "! ", "/ "};
    string p1 = "{}[]():,.+*-";
    string big = "9223372036854775807";
    int n;
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0: begin
        put(8'("a" + $urandom_range(0, 25)));
        repeat ($urandom_range(0, 4))
          put($urandom_range(0, 1) ? 8'("0" + $urandom_range(0, 9))
                                   : 8'("A" + $urandom_range(0, 25)));
      end
      1: begin
        case ($urandom_range(0, 3))
          0: for (int i = 0; i < big.len(); i++) put(big[i]);
          1: repeat (19 + $urandom_range(0, 1)) put("9");
          default: repeat ($urandom_range(1, 4)) put(8'("0" + $urandom_range(0, 9)));
        endcase
      end
      2: begin
        put("\"");
        n = $urandom_range(0, 4);
        repeat (n) begin
          case ($urandom_range(0, 5))
            0: begin
              put("\\");
              case ($urandom_range(0, 4))
                0: put("\""); 1: put("\\"); 2: put("n"); 3: put("t");
                default: put("x");
              endcase
            end
            1: put(CH_NUL);
            default: begin
              c = 8'($urandom_range(8'h20, 8'hFF));
              put((c == "\"" || c == "\\") ? "s" : c);
            end
          endcase
        end
        if ($urandom_range(0, 7) == 0) put(CH_LF);
        else if ($urandom_range(0, 7) != 0) put("\"");
      end
      3: begin
        if ($urandom_range(0, 1)) begin
          n = $urandom_range(0, p2.size() - 1);
          put(p2[n][0]); put(p2[n][1]);
        end else put(p1[$urandom_range(0, p1.len() - 1)]);
      end
      4: begin
        put("/"); put("/");
        repeat ($urandom_range(0, 3)) begin
          c = 8'($urandom_range(0, 255));
          put(c == CH_LF ? CH_NUL : c);
        end
        put(CH_LF);
      end
      5: put(($urandom_range(0, 3) == 0) ? CH_LF : " ");
      6: put(8'($urandom_range(0, 255)));
      7: put_item(8'($urandom_range(0, 255)), 1'b1);
      default: put(($urandom_range(0, 1)) ? CH_TAB : CH_CR);
    endcase
  endfunction

  // drive one item and wait for its transfer
  task automatic send_item(input logic [7:0] b, input logic eos, output int first);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.source_byte <= b;
    in_if.end_of_source <= eos;
    do @(posedge clk); while (!in_if.ready);
    first = lx_accept(b, eos);
  endtask

  // result checker
  always @(posedge clk) begin
    dbt_pkg::rec_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_recs.size() == 0) begin
        mismatches++;
        $display("%0t unexpected record, exp none, act kind %0d err %0d", $time,
                 out_if.token_kind, out_if.error_code);
      end else begin
        e = pending_recs.pop_front();
        if (out_if.token_kind !== e.kind || out_if.start_line !== e.line ||
            out_if.start_column !== e.col || out_if.has_byte !== e.has_byte ||
            out_if.text_byte !== e.text || out_if.token_done !== e.done ||
            out_if.int_value !== e.ival || out_if.error_code !== 3'(e.err) ||
            out_if.last_of_run !== e.last) begin
          mismatches++;
          $display("%0t mismatch exp k%0d l%0d c%0d hb%0d t%h d%0d v%0d e%0d last%0d",
                   $time, e.kind, e.line, e.col, e.has_byte, e.text, e.done, e.ival,
                   e.err, e.last);
          $display("%0t          act k%0d l%0d c%0d hb%0d t%h d%0d v%0d e%0d last%0d",
                   $time, out_if.token_kind, out_if.start_line, out_if.start_column,
                   out_if.has_byte, out_if.text_byte, out_if.token_done,
                   out_if.int_value, out_if.error_code, out_if.last_of_run);
        end
      end
    end
  end

  // receiver: random stalls plus a long hold-off on request
  int hold_taken = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_req != hold_taken) begin
      hold_left = HOLD_CYCLES;
      hold_taken = hold_req;
    end
    if (hold_left > 0) hold_left--;
    out_if.ready <= rst_n && hold_left == 0 && $urandom_range(0, 99) >= recv_stall_pct;
  end

  initial begin
    #(12ns * 200000);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int first;
    int wait_cnt;
    in_if.valid = 1'b0;
    in_if.source_byte = 8'h00;
    in_if.end_of_source = 1'b0;
    lx_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, no idling
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].b, dir_rows[i].eos, first);
      if (dir_rows[i].chk) begin
        if (pending_recs.size() <= first) begin
          mismatches++;
          $display("%0t row %0d: exp kind %0d err %0d, act no record", $time, i,
                   dir_rows[i].kind, dir_rows[i].err);
        end else if (pending_recs[first].kind !== dir_rows[i].kind ||
                     pending_recs[first].err !== dir_rows[i].err) begin
          mismatches++;
          $display("%0t row %0d: exp kind %0d err %0d, act kind %0d err %0d", $time, i,
                   dir_rows[i].kind, dir_rows[i].err, pending_recs[first].kind,
                   pending_recs[first].err);
        end
      end
    end

    // random phases: none, sender idle, receiver stall (long hold-off), both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 71 : (ph == 3) ? 24 : 0;
      recv_stall_pct = (ph == 2) ? 71 : (ph == 3) ? 24 : 0;
      if (ph == 2) hold_req = hold_req + 1;
      while (src_bytes.size() < 16) gen_fragment();
      put_item(8'h00, 1'b1);
      while (src_bytes.size() > 0)
        send_item(src_bytes.pop_front(), src_eos.pop_front(), first);
    end
    in_if.valid <= 1'b0;

    // drain
    wait_cnt = 0;
    while (pending_recs.size() > 0 && wait_cnt < 20000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_recs.size() == 0) begin
      $display("CHECK OK");
    end else begin
      if (pending_recs.size() > 0)
        $display("%0t %0d records never arrived", $time, pending_recs.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
